>>> rtl/dedup_fifo_archive_macros.svh
// ----------------------------------------------------------------------------
// dedup_fifo_archive_macros
// Assertion macros used by the archive RTL.
// ----------------------------------------------------------------------------
`ifndef DEDUP_FIFO_ARCHIVE_MACROS_SVH
`define DEDUP_FIFO_ARCHIVE_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define DFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define DFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Widths, codes and shared types of the deduplicating FIFO archive.
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int PROG_W = 16;
    localparam int HASH_W = 64;
    localparam int RES_W  = 64;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 6;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

    // word index of the capacity register (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_INSERT    = 2'd0;
    localparam t_kind KIND_DUPLICATE = 2'd1;
    localparam t_kind KIND_EVICT     = 2'd2;
    localparam t_kind KIND_CLEAR     = 2'd3;

    typedef struct packed {
        logic [PROG_W-1:0] prog;
        logic [HASH_W-1:0] hash;
        logic [RES_W-1:0]  result;
    } t_entry;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic compare;
        logic shift;
        logic append;
    } t_cell_ctl;

endpackage

>>> rtl/dedup_fifo_archive.sv
// ----------------------------------------------------------------------------
// dedup_fifo_archive
// Insertion-ordered archive of (program, hash, result) words with duplicate
// rejection and oldest-first eviction down to a programmable capacity.
// ----------------------------------------------------------------------------
// An add has two steps: the accept cycle, in which every cell compares
// its entry against the incoming program and hash, and an update cycle that
// reduces the match bits, appends and emits the insert or duplicate word.
// Each eviction then adds two more steps: one to compare every cell against
// the head's hash and one to shift the row and emit the report. A clear
// ends at accept; busy is high from the cycle after an add's accept until
// the last word has been produced. Result words appear on the o_ ports for
// exactly one cycle, flagged by o_valid, and cannot be held off: the
// receiver must take every word as it comes. o_last marks an input's final
// word. Capacity is taken as 1 when written as zero and as DEPTH-1 when
// larger than that.
// ----------------------------------------------------------------------------
`include "dedup_fifo_archive_macros.svh"

module dedup_fifo_archive #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [dfa_pkg::PROG_W-1:0]          i_program_id,
    input  logic [dfa_pkg::HASH_W-1:0]          i_data_hash,
    input  logic [dfa_pkg::RES_W-1:0]           i_result_word,
    // result channel
    output logic                                o_valid,
    output logic [dfa_pkg::KIND_W-1:0]          o_kind,
    output logic [dfa_pkg::PROG_W-1:0]          o_evicted_program,
    output logic [dfa_pkg::HASH_W-1:0]          o_evicted_hash,
    output logic [dfa_pkg::RES_W-1:0]           o_evicted_result,
    output logic                                o_hash_released,
    output logic [dfa_pkg::CNT_W-1:0]           o_entry_count,
    output logic [dfa_pkg::CNT_W-1:0]           o_distinct_hashes,
    output logic                                o_last,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dfa_pkg::APB_AW-1:0]          paddr,
    input  logic [dfa_pkg::APB_DW-1:0]          pwdata,
    output logic [dfa_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CAPW  = dfa_pkg::CAP_W;
    localparam int KW    = (NW > CAPW) ? NW : CAPW;
    localparam int OCW   = dfa_pkg::CNT_W;
    localparam int DW    = dfa_pkg::APB_DW;
    localparam logic [KW-1:0] MAX_CAP = KW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_EV_CMP,
        S_EV_SHIFT
    } t_state;

    t_state                     r_state;
    logic [NW-1:0]              r_count;
    logic [NW-1:0]              r_hcount;
    logic [CAPW-1:0]            r_cap;
    dfa_pkg::t_entry            r_new;

    logic                       r_valid;
    dfa_pkg::t_kind             r_kind;
    logic [dfa_pkg::PROG_W-1:0] r_ev_prog;
    logic [dfa_pkg::HASH_W-1:0] r_ev_hash;
    logic [dfa_pkg::RES_W-1:0]  r_ev_res;
    logic                       r_released;
    logic [NW-1:0]              r_out_count;
    logic [NW-1:0]              r_out_hcount;
    logic                       r_last;

    dfa_pkg::t_cell_ctl         w_ctl;
    logic [dfa_pkg::HASH_W-1:0] w_key_hash;
    dfa_pkg::t_entry            w_entry [DEPTH];
    logic [DEPTH-1:0]           w_valid;
    logic [DEPTH-1:0]           w_hit_hash;
    logic [DEPTH-1:0]           w_hit_pair;

    logic                       w_accept;
    logic                       w_cfg_wr;
    logic [KW-1:0]              w_cap_raw;
    logic [KW-1:0]              w_cap;
    logic [NW-1:0]              w_cnt_inc;
    logic [NW-1:0]              w_cnt_dec;
    logic                       w_any_pair;
    logic                       w_any_hash;
    logic                       w_released;
    logic                       w_more_ins;
    logic                       w_more_ev;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // ---------------------------------------------------------------- config
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == dfa_pkg::REG_CAPACITY);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == dfa_pkg::REG_CAPACITY) ? DW'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= dfa_pkg::CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[CAPW-1:0];
        end
    end

    // clamp capacity into 1 .. DEPTH-1
    assign w_cap_raw = KW'(r_cap);
    always_comb begin
        priority if (w_cap_raw == '0) begin
            w_cap = KW'(1);
        end else if (w_cap_raw > MAX_CAP) begin
            w_cap = MAX_CAP;
        end else begin
            w_cap = w_cap_raw;
        end
    end

    // ----------------------------------------------------------------- cells
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == dfa_pkg::FUNC_CLEAR) begin
                        w_ctl.clear = 1'b1;
                    end else begin
                        w_ctl.compare = 1'b1;
                    end
                end
            end
            S_UPD:      w_ctl.append  = !w_any_pair;
            S_EV_CMP:   w_ctl.compare = 1'b1;
            S_EV_SHIFT: w_ctl.shift   = 1'b1;
        endcase
    end

    // incoming hash on accept, head hash while evicting
    assign w_key_hash = (r_state == S_IDLE) ? i_data_hash : w_entry[0].hash;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dfa_pkg::t_entry w_nbr_entry;
        logic            w_nbr_valid;

        if (g == DEPTH - 1) begin : g_tail
            assign w_nbr_entry = '0;
            assign w_nbr_valid = 1'b0;
        end else begin : g_body
            assign w_nbr_entry = w_entry[g+1];
            assign w_nbr_valid = w_valid[g+1];
        end

        dfa_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_append_idx (r_count[CW-1:0]),
            .i_new_entry  (r_new),
            .i_key_prog   (i_program_id),
            .i_key_hash   (w_key_hash),
            .i_nbr_entry  (w_nbr_entry),
            .i_nbr_valid  (w_nbr_valid),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_hit_hash   (w_hit_hash[g]),
            .o_hit_pair   (w_hit_pair[g])
        );
    end

    // ------------------------------------------------------------- sequencer
    assign w_any_pair = |w_hit_pair;
    assign w_any_hash = |w_hit_hash;
    // the head always matches itself: only the cells behind it count
    assign w_released = !(|w_hit_hash[DEPTH-1:1]);
    assign w_cnt_inc  = r_count + 1'b1;
    assign w_cnt_dec  = r_count - 1'b1;
    assign w_more_ins = (KW'(w_cnt_inc) > w_cap);
    assign w_more_ev  = (KW'(w_cnt_dec) > w_cap);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new.prog   <= i_program_id;
            r_new.hash   <= i_data_hash;
            r_new.result <= i_result_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hcount <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_func == dfa_pkg::FUNC_CLEAR)) begin
                        r_count      <= '0;
                        r_hcount     <= '0;
                        r_valid      <= 1'b1;
                        r_kind       <= dfa_pkg::KIND_CLEAR;
                        r_ev_prog    <= '0;
                        r_ev_hash    <= '0;
                        r_ev_res     <= '0;
                        r_released   <= 1'b0;
                        r_out_count  <= '0;
                        r_out_hcount <= '0;
                        r_last       <= 1'b1;
                    end else if (w_accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_valid    <= 1'b1;
                    r_ev_prog  <= '0;
                    r_ev_hash  <= '0;
                    r_ev_res   <= '0;
                    r_released <= 1'b0;
                    if (w_any_pair) begin
                        // duplicate: drop the word, counts stand
                        r_kind       <= dfa_pkg::KIND_DUPLICATE;
                        r_out_count  <= r_count;
                        r_out_hcount <= r_hcount;
                        r_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_kind      <= dfa_pkg::KIND_INSERT;
                        r_count     <= w_cnt_inc;
                        r_out_count <= w_cnt_inc;
                        if (w_any_hash) begin
                            r_out_hcount <= r_hcount;
                        end else begin
                            r_hcount     <= r_hcount + 1'b1;
                            r_out_hcount <= r_hcount + 1'b1;
                        end
                        r_last  <= !w_more_ins;
                        r_state <= w_more_ins ? S_EV_CMP : S_IDLE;
                    end
                end
                S_EV_CMP: begin
                    r_state <= S_EV_SHIFT;
                end
                S_EV_SHIFT: begin
                    r_valid     <= 1'b1;
                    r_kind      <= dfa_pkg::KIND_EVICT;
                    r_ev_prog   <= w_entry[0].prog;
                    r_ev_hash   <= w_entry[0].hash;
                    r_ev_res    <= w_entry[0].result;
                    r_released  <= w_released;
                    r_count     <= w_cnt_dec;
                    r_out_count <= w_cnt_dec;
                    if (w_released && (r_hcount != '0)) begin
                        r_hcount     <= r_hcount - 1'b1;
                        r_out_hcount <= r_hcount - 1'b1;
                    end else begin
                        r_out_hcount <= r_hcount;
                    end
                    r_last  <= !w_more_ev;
                    r_state <= w_more_ev ? S_EV_CMP : S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_kind;
    assign o_evicted_program = r_ev_prog;
    assign o_evicted_hash    = r_ev_hash;
    assign o_evicted_result  = r_ev_res;
    assign o_hash_released   = r_released;
    assign o_entry_count     = OCW'(r_out_count);
    assign o_distinct_hashes = OCW'(r_out_hcount);
    assign o_last            = r_last;

    // ------------------------------------------------------------ assertions
    `DFA_ASSERT_NOW(a_hash_le_count, i_clk, i_rst_n, 1'b1, (r_hcount <= r_count), "distinct hashes exceed entries")

    `DFA_ASSERT_NOW(a_valid_packed, i_clk, i_rst_n, 1'b1, ($countones(w_valid) == int'(r_count)), "valid cells disagree with entry count")

    `DFA_ASSERT_NOW(a_more_follows, i_clk, i_rst_n, (o_valid && !o_last), busy, "non-final word while sequencer idle")

    `DFA_ASSERT_NEXT(a_clear_word, i_clk, i_rst_n, (w_accept && (i_func == dfa_pkg::FUNC_CLEAR)), (o_valid && (o_kind == dfa_pkg::KIND_CLEAR) && (o_entry_count == '0) && o_last), "clear not reported")

endmodule

>>> rtl/dfa_cell.sv
// ----------------------------------------------------------------------------
// dfa_cell
// One archive slot: holds an entry, compares it against the broadcast key
// and takes its neighbour's entry when the row shifts towards the head.
// ----------------------------------------------------------------------------
module dfa_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dfa_pkg::t_cell_ctl          i_ctl,
    input  logic [CW-1:0]               i_append_idx,
    input  dfa_pkg::t_entry             i_new_entry,
    input  logic [dfa_pkg::PROG_W-1:0]  i_key_prog,
    input  logic [dfa_pkg::HASH_W-1:0]  i_key_hash,
    input  dfa_pkg::t_entry             i_nbr_entry,
    input  logic                        i_nbr_valid,
    output dfa_pkg::t_entry             o_entry,
    output logic                        o_valid,
    output logic                        o_hit_hash,
    output logic                        o_hit_pair
);

    dfa_pkg::t_entry r_entry;
    logic            r_valid;
    logic            r_hit_hash;
    logic            r_hit_pair;
    logic            w_mine;
    logic            w_hash_eq;

    assign w_mine    = i_ctl.append && (i_append_idx == CW'(IDX));
    assign w_hash_eq = r_valid && (r_entry.hash == i_key_hash);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_hit_hash <= 1'b0;
            r_hit_pair <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.shift) begin
                r_valid <= i_nbr_valid;
            end else if (w_mine) begin
                r_valid <= 1'b1;
            end
            if (i_ctl.compare) begin
                r_hit_hash <= w_hash_eq;
                r_hit_pair <= w_hash_eq && (r_entry.prog == i_key_prog);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_nbr_entry;
        end else if (w_mine) begin
            r_entry <= i_new_entry;
        end
    end

    assign o_entry    = r_entry;
    assign o_valid    = r_valid;
    assign o_hit_hash = r_hit_hash;
    assign o_hit_pair = r_hit_pair;

endmodule

>>> bench/dedup_fifo_archive_tb.sv
// ----------------------------------------------------------------------------
// dedup_fifo_archive_tb
// Drives add and clear commands into the archive and checks every result word
// against a queue-based model of the store. Capacity is rewritten between
// phases once the block is quiet: reset value, one, zero, small and wide.
// ----------------------------------------------------------------------------
module dedup_fifo_archive_tb;

    import dfa_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        t_kind             kind;
        logic [PROG_W-1:0] prog;
        logic [HASH_W-1:0] hash;
        logic [RES_W-1:0]  result;
        logic              released;
        logic [CNT_W-1:0]  entries;
        logic [CNT_W-1:0]  hashes;
        logic              last;
    } t_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_func = FUNC_ADD;
    logic [PROG_W-1:0]   i_program_id = '0;
    logic [HASH_W-1:0]   i_data_hash = '0;
    logic [RES_W-1:0]    i_result_word = '0;
    logic                o_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [PROG_W-1:0]   o_evicted_program;
    logic [HASH_W-1:0]   o_evicted_hash;
    logic [RES_W-1:0]    o_evicted_result;
    logic                o_hash_released;
    logic [CNT_W-1:0]    o_entry_count;
    logic [CNT_W-1:0]    o_distinct_hashes;
    logic                o_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // model of the archive
    t_entry              archive_q[$];
    int                  distinct_model;
    logic [CAP_W-1:0]    capacity_model;
    t_report             expected_reports[$];

    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;
    bit                  gaps_on = 1'b1;
    logic [PROG_W-1:0]   prog_pool [4];
    logic [HASH_W-1:0]   hash_pool [6];

    dedup_fifo_archive u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_program_id      (i_program_id),
        .i_data_hash       (i_data_hash),
        .i_result_word     (i_result_word),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_evicted_program (o_evicted_program),
        .o_evicted_hash    (o_evicted_hash),
        .o_evicted_result  (o_evicted_result),
        .o_hash_released   (o_hash_released),
        .o_entry_count     (o_entry_count),
        .o_distinct_hashes (o_distinct_hashes),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic bit hash_stored(input logic [HASH_W-1:0] hash);
        foreach (archive_q[i]) begin
            if (archive_q[i].hash == hash) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit pair_stored(input logic [PROG_W-1:0] prog,
                                       input logic [HASH_W-1:0] hash);
        foreach (archive_q[i]) begin
            if (archive_q[i].hash == hash && archive_q[i].prog == prog) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the result words of one accepted command and update the model.
    function automatic void predict_archive(input logic func,
                                            input logic [PROG_W-1:0] prog,
                                            input logic [HASH_W-1:0] hash,
                                            input logic [RES_W-1:0] result);
        int      eff_cap;
        t_report w;
        t_entry  head;
        t_entry  fresh;
        eff_cap = (capacity_model == '0) ? 1 : int'(capacity_model);
        w = '0;
        if (func == FUNC_CLEAR) begin
            archive_q.delete();
            distinct_model = 0;
            w.kind = KIND_CLEAR;
            w.last = 1'b1;
            expected_reports = {expected_reports, w};
            return;
        end
        if (pair_stored(prog, hash)) begin
            w.kind    = KIND_DUPLICATE;
            w.entries = CNT_W'(archive_q.size());
            w.hashes  = CNT_W'(distinct_model);
            w.last    = 1'b1;
            expected_reports = {expected_reports, w};
            return;
        end
        if (!hash_stored(hash)) distinct_model++;
        fresh.prog   = prog;
        fresh.hash   = hash;
        fresh.result = result;
        archive_q = {archive_q, fresh};
        w.kind    = KIND_INSERT;
        w.entries = CNT_W'(archive_q.size());
        w.hashes  = CNT_W'(distinct_model);
        w.last    = (archive_q.size() <= eff_cap);
        expected_reports = {expected_reports, w};
        // evict oldest first until within capacity
        while (archive_q.size() > eff_cap) begin
            head = archive_q[0];
            archive_q.delete(0);
            w = '0;
            w.kind     = KIND_EVICT;
            w.prog     = head.prog;
            w.hash     = head.hash;
            w.result   = head.result;
            w.released = !hash_stored(head.hash);
            if (w.released && distinct_model > 0) distinct_model--;
            w.entries  = CNT_W'(archive_q.size());
            w.hashes   = CNT_W'(distinct_model);
            w.last     = (archive_q.size() <= eff_cap);
            expected_reports = {expected_reports, w};
        end
    endfunction

    // Leaves start high on return, so back-to-back words need no gap.
    task automatic send_item(input logic func, input logic [PROG_W-1:0] prog,
                             input logic [HASH_W-1:0] hash,
                             input logic [RES_W-1:0] result);
        if (gaps_on && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_program_id  <= prog;
        i_data_hash   <= hash;
        i_result_word <= result;
        do @(posedge i_clk); while (busy);
        predict_archive(func, prog, hash, result);
    endtask

    task automatic send_random(input int clear_pct);
        logic              func;
        logic [PROG_W-1:0] prog;
        logic [HASH_W-1:0] hash;
        func = ($urandom_range(0, 99) < clear_pct) ? FUNC_CLEAR : FUNC_ADD;
        // half the fields come from small pools so duplicates and shared hashes occur
        prog = $urandom_range(0, 1) ? prog_pool[$urandom_range(0, 3)] : PROG_W'($urandom);
        hash = $urandom_range(0, 1) ? hash_pool[$urandom_range(0, 5)] : {$urandom, $urandom};
        send_item(func, prog, hash, {$urandom, $urandom});
    endtask

    task automatic drain_archive();
        start <= 1'b0;
        while (expected_reports.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write capacity while idle, then read it straight back.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_archive();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_model = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("capacity readback", 64'(prdata[CAP_W-1:0]), 64'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_extremes();
        send_item(FUNC_CLEAR, '0, '0, '0);
        send_item(FUNC_ADD, '0, '0, '0);
        send_item(FUNC_ADD, '1, '1, '1);
        send_item(FUNC_ADD, '0, '0, '1);
        send_item(FUNC_ADD, '1, '0, {$urandom, $urandom});
        send_item(FUNC_ADD, '0, '1, {$urandom, $urandom});
        send_item(FUNC_CLEAR, '1, '1, '1);
    endtask

    task automatic test_capacity_one();
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        logic [HASH_W-1:0] h3;
        h1 = {$urandom, $urandom};
        h2 = h1 ^ 64'h8000_0000_0000_0001;
        h3 = ~h1;
        write_capacity(6'd1);
        send_item(FUNC_ADD, 16'd1, h1, {$urandom, $urandom});
        send_item(FUNC_ADD, 16'd2, h2, {$urandom, $urandom});
        // evicted entry's hash still held by the newcomer
        send_item(FUNC_ADD, 16'd3, h2, {$urandom, $urandom});
        send_item(FUNC_ADD, 16'd3, h2, {$urandom, $urandom});
        send_item(FUNC_ADD, 16'd3, h3, {$urandom, $urandom});
    endtask

    task automatic test_capacity_zero();
        logic [HASH_W-1:0] h4;
        h4 = {$urandom, $urandom};
        write_capacity(6'd0);
        send_item(FUNC_ADD, 16'd10, h4, {$urandom, $urandom});
        send_item(FUNC_ADD, 16'd11, h4, {$urandom, $urandom});
        // re-adding an evicted pair is no longer a duplicate
        send_item(FUNC_ADD, 16'd10, h4, {$urandom, $urandom});
        send_item(FUNC_CLEAR, '0, '0, '0);
    endtask

    // Fill the store at full capacity; the first stretch runs without gaps.
    task automatic test_random_fill();
        foreach (prog_pool[i]) prog_pool[i] = PROG_W'($urandom);
        foreach (hash_pool[i]) hash_pool[i] = {$urandom, $urandom};
        write_capacity(6'd63);
        gaps_on = 1'b0;
        for (int n = 0; n < 120; n++) begin
            if (n == 70) gaps_on = 1'b1;
            send_random(0);
        end
    endtask

    // Shrinking to one right after a fill forces the longest eviction run.
    task automatic test_mass_eviction();
        write_capacity(6'd1);
        for (int n = 0; n < 40; n++) send_random(3);
    endtask

    task automatic test_random_small();
        write_capacity(CAP_W'($urandom_range(2, 8)));
        for (int n = 0; n < 90; n++) send_random(5);
        write_capacity(6'd0);
        for (int n = 0; n < 30; n++) send_random(5);
    endtask

    task automatic test_random_wide();
        write_capacity(CAP_W'($urandom_range(9, 62)));
        for (int n = 0; n < 80; n++) send_random(2);
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_report w;
        if (i_rst_n && o_valid) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                w = expected_reports[0];
                expected_reports.delete(0);
                check_field("kind", 64'(o_kind), 64'(w.kind));
                check_field("evicted_program", 64'(o_evicted_program), 64'(w.prog));
                check_field("evicted_hash", o_evicted_hash, w.hash);
                check_field("evicted_result", o_evicted_result, w.result);
                check_field("hash_released", 64'(o_hash_released), 64'(w.released));
                check_field("entry_count", 64'(o_entry_count), 64'(w.entries));
                check_field("distinct_hashes", 64'(o_distinct_hashes), 64'(w.hashes));
                check_field("last", 64'(o_last), 64'(w.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        archive_q.delete();
        distinct_model = 0;
        capacity_model = CAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_capacity_one();
        test_capacity_zero();
        test_random_fill();
        test_mass_eviction();
        test_random_small();
        test_random_wide();
        drain_archive();
        repeat (20) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_reports.size()));
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dfa_pkg.sv
rtl/dfa_cell.sv
rtl/dedup_fifo_archive.sv
bench/dedup_fifo_archive_tb.sv
